// ----- rtl/alfe_pkg.sv -----
// Shared types and constants for the addressable LED frame encoder.
// No dependencies; every other file refers to it by scoped names.
package alfe_pkg;

    localparam int COLOR_W      = 8;
    localparam int BITS_PER_LED = 24;
    localparam int BIT_W        = 5;
    localparam int PCT_W        = 7;
    localparam int DUTY_W       = 16;
    localparam int SLOTS_W      = 8;
    localparam int CMD_W        = 3;
    localparam int INDEX_W      = 16;
    localparam int STATUS_W     = 2;
    localparam int REG_W        = 3;

    localparam int PCT_MAX      = 100;
    localparam int PROD_W       = 15;
    localparam int RECIP_W      = 13;
    localparam int QMUL_W       = PROD_W + RECIP_W;
    localparam int SCALE_RECIP  = 5243;
    localparam int SCALE_SHIFT  = 19;

    localparam int BRIGHT_RST   = 100;
    localparam int ONE_RST      = 58;
    localparam int ZERO_RST     = 29;
    localparam int LATCH_RST    = 0;
    localparam int SLOTS_RST    = 50;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 3'd0,
        CMD_FILL  = 3'd1,
        CMD_CLEAR = 3'd2,
        CMD_START = 3'd3,
        CMD_TICK  = 3'd4
    } cmd_e_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_BUSY  = 2'd2
    } status_e_t;

    typedef enum logic [REG_W-1:0] {
        REG_BRIGHTNESS = 3'd0,
        REG_ONE_DUTY   = 3'd1,
        REG_ZERO_DUTY  = 3'd2,
        REG_LATCH_DUTY = 3'd3,
        REG_LATCH_SLOT = 3'd4
    } reg_e_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] pixel_index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DUTY_W-1:0]   duty_code;
        logic                slot_valid;
        logic                frame_last;
        logic                busy_out;
    } rsp_t;

    typedef struct packed {
        logic [REG_W-1:0]  index;
        logic [DUTY_W-1:0] value;
    } cfg_t;

    typedef struct packed {
        logic item_load;
        logic eval;
        logic pix_we;
        logic pix_sweep;
        logic pix_zero;
        logic cnt_inc;
        logic snap_issue;
        logic frame_start;
        logic tick_step;
        logic res_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             idx_ok;
        logic             sending;
        logic             cnt_last;
        logic             pipe_empty;
    } ctrl_stat_t;

endpackage

// ----- rtl/alfe_if.sv -----
// Handshake interfaces for the command, result and configuration channels.
// Depends on alfe_pkg for the payload types.
interface alfe_req_if;
    logic            valid;
    logic            ready;
    alfe_pkg::req_t  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface alfe_rsp_if;
    logic            valid;
    logic            ready;
    alfe_pkg::rsp_t  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface alfe_cfg_if;
    logic            valid;
    logic            ready;
    alfe_pkg::cfg_t  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/alfe_ctrl.sv -----
// Sequencer of the LED frame encoder: decodes each item and steps the datapath.
// Depends on alfe_pkg for command and status structs.
module alfe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  alfe_pkg::ctrl_stat_t stat,
    output alfe_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_DECODE,
        ST_SWEEP,
        ST_SNAP_ISSUE,
        ST_SNAP_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLR:
            begin
                cmd.pix_we    = 1'b1;
                cmd.pix_sweep = 1'b1;
                cmd.pix_zero  = 1'b1;
                cmd.cnt_inc   = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_DONE;
                case (stat.cmd)
                    alfe_pkg::CMD_WRITE: cmd.pix_we = stat.idx_ok;
                    alfe_pkg::CMD_FILL:  state_next = ST_SWEEP;
                    alfe_pkg::CMD_CLEAR: state_next = ST_SWEEP;
                    alfe_pkg::CMD_START:
                    begin
                        if (!stat.sending)
                        begin
                            state_next = ST_SNAP_ISSUE;
                        end
                    end
                    alfe_pkg::CMD_TICK:  cmd.tick_step = stat.sending;
                    default:             state_next = ST_DONE;
                endcase
            end
            ST_SWEEP:
            begin
                cmd.pix_we    = 1'b1;
                cmd.pix_sweep = 1'b1;
                cmd.pix_zero  = (stat.cmd == alfe_pkg::CMD_CLEAR);
                cmd.cnt_inc   = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SNAP_ISSUE:
            begin
                cmd.snap_issue = 1'b1;
                cmd.cnt_inc    = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = ST_SNAP_DRAIN;
                end
            end
            ST_SNAP_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    cmd.frame_start = 1'b1;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.res_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- rtl/alfe_datapath.sv -----
// Datapath of the LED frame encoder: pixel and frame memories, brightness
// scaling pipeline, frame cursors, configuration registers and result register.
// Depends on alfe_pkg for payload, command and status types.
module alfe_datapath #(
    parameter int LED_COUNT = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  alfe_pkg::req_t       req_data,
    input  logic                 cfg_we,
    input  alfe_pkg::cfg_t       cfg_data,
    input  alfe_pkg::ctrl_cmd_t  cmd,
    output alfe_pkg::ctrl_stat_t stat,
    output alfe_pkg::rsp_t       rsp_data
);

    localparam int ADDR_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int LC_W   = $clog2(LED_COUNT + 1);
    localparam int PIX_W  = alfe_pkg::BITS_PER_LED;
    localparam int CW     = alfe_pkg::COLOR_W;

    alfe_pkg::req_t item_reg;

    logic [alfe_pkg::PCT_W-1:0]   bright_reg;
    logic [alfe_pkg::DUTY_W-1:0]  one_duty_reg;
    logic [alfe_pkg::DUTY_W-1:0]  zero_duty_reg;
    logic [alfe_pkg::DUTY_W-1:0]  latch_duty_reg;
    logic [alfe_pkg::SLOTS_W-1:0] latch_slots_reg;

    logic [PIX_W-1:0] pixel_store [LED_COUNT];
    logic [PIX_W-1:0] frame_store [LED_COUNT];

    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] pix_waddr;
    logic [PIX_W-1:0]  pix_wdata;
    logic [PIX_W-1:0]  pix_rdata_reg;

    logic                      v1_reg, v2_reg;
    logic [ADDR_W-1:0]         a1_reg, a2_reg;
    logic [alfe_pkg::PROD_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic [alfe_pkg::QMUL_W-1:0] qm_r, qm_g, qm_b;
    logic [CW-1:0]             q_r, q_g, q_b;

    logic                         sending_reg;
    logic [LC_W-1:0]              led_cursor_reg;
    logic [alfe_pkg::BIT_W-1:0]   bit_cursor_reg;
    logic [alfe_pkg::SLOTS_W-1:0] latch_count_reg;
    logic [ADDR_W-1:0]            frame_raddr;
    logic [PIX_W-1:0]             frame_rdata_reg;

    logic                         in_bits;
    logic                         frame_bit;
    logic                         bit_wrap;
    logic [alfe_pkg::SLOTS_W-1:0] lc_inc;
    logic [alfe_pkg::DUTY_W-1:0]  tick_duty;
    logic                         tick_last;
    logic                         idx_ok;
    logic [alfe_pkg::STATUS_W-1:0] status_calc;

    logic [alfe_pkg::STATUS_W-1:0] status_reg;
    logic [alfe_pkg::DUTY_W-1:0]   duty_reg;
    logic                          slot_valid_reg;
    logic                          frame_last_reg;
    alfe_pkg::rsp_t                rsp_reg;
    logic [alfe_pkg::PCT_W-1:0]    cfg_pct;

    assign idx_ok = (item_reg.pixel_index < alfe_pkg::INDEX_W'(LED_COUNT));

    assign stat.cmd        = item_reg.cmd;
    assign stat.idx_ok     = idx_ok;
    assign stat.sending    = sending_reg;
    assign stat.cnt_last   = (cnt_reg == ADDR_W'(LED_COUNT - 1));
    assign stat.pipe_empty = !v1_reg && !v2_reg;

    assign rsp_data = rsp_reg;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_reg <= req_data;
        end
    end

    // configuration registers
    assign cfg_pct = cfg_data.value[alfe_pkg::PCT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg      <= alfe_pkg::PCT_W'(alfe_pkg::BRIGHT_RST);
            one_duty_reg    <= alfe_pkg::DUTY_W'(alfe_pkg::ONE_RST);
            zero_duty_reg   <= alfe_pkg::DUTY_W'(alfe_pkg::ZERO_RST);
            latch_duty_reg  <= alfe_pkg::DUTY_W'(alfe_pkg::LATCH_RST);
            latch_slots_reg <= alfe_pkg::SLOTS_W'(alfe_pkg::SLOTS_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_data.index)
                alfe_pkg::REG_BRIGHTNESS:
                    bright_reg <= (cfg_pct > alfe_pkg::PCT_W'(alfe_pkg::PCT_MAX)) ?
                                  alfe_pkg::PCT_W'(alfe_pkg::PCT_MAX) : cfg_pct;
                alfe_pkg::REG_ONE_DUTY:   one_duty_reg   <= cfg_data.value;
                alfe_pkg::REG_ZERO_DUTY:  zero_duty_reg  <= cfg_data.value;
                alfe_pkg::REG_LATCH_DUTY: latch_duty_reg <= cfg_data.value;
                alfe_pkg::REG_LATCH_SLOT:
                    latch_slots_reg <= cfg_data.value[alfe_pkg::SLOTS_W-1:0];
                default: ;
            endcase
        end
    end

    // sweep counter, wraps to zero after the last entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= stat.cnt_last ? '0 : cnt_reg + ADDR_W'(1);
        end
    end

    // pixel store
    assign pix_waddr = cmd.pix_sweep ? cnt_reg : item_reg.pixel_index[ADDR_W-1:0];
    assign pix_wdata = cmd.pix_zero ? '0 : {item_reg.red, item_reg.green, item_reg.blue};

    always_ff @(posedge clk)
    begin
        if (cmd.pix_we)
        begin
            pixel_store[pix_waddr] <= pix_wdata;
        end
        pix_rdata_reg <= pixel_store[cnt_reg];
    end

    // scaling pipeline: read, multiply by percent, divide by 100 via reciprocal
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.snap_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg     <= cnt_reg;
        a2_reg     <= a1_reg;
        prod_r_reg <= alfe_pkg::PROD_W'(pix_rdata_reg[3*CW-1:2*CW]) *
                      alfe_pkg::PROD_W'(bright_reg);
        prod_g_reg <= alfe_pkg::PROD_W'(pix_rdata_reg[2*CW-1:CW]) *
                      alfe_pkg::PROD_W'(bright_reg);
        prod_b_reg <= alfe_pkg::PROD_W'(pix_rdata_reg[CW-1:0]) *
                      alfe_pkg::PROD_W'(bright_reg);
    end

    assign qm_r = alfe_pkg::QMUL_W'(prod_r_reg) * alfe_pkg::QMUL_W'(alfe_pkg::SCALE_RECIP);
    assign qm_g = alfe_pkg::QMUL_W'(prod_g_reg) * alfe_pkg::QMUL_W'(alfe_pkg::SCALE_RECIP);
    assign qm_b = alfe_pkg::QMUL_W'(prod_b_reg) * alfe_pkg::QMUL_W'(alfe_pkg::SCALE_RECIP);
    assign q_r  = qm_r[alfe_pkg::SCALE_SHIFT +: CW];
    assign q_g  = qm_g[alfe_pkg::SCALE_SHIFT +: CW];
    assign q_b  = qm_b[alfe_pkg::SCALE_SHIFT +: CW];

    // frame store, GRB order
    assign in_bits     = (led_cursor_reg < LC_W'(LED_COUNT));
    assign frame_raddr = in_bits ? led_cursor_reg[ADDR_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            frame_store[a2_reg] <= {q_g, q_r, q_b};
        end
        frame_rdata_reg <= frame_store[frame_raddr];
    end

    // slot tick
    assign frame_bit = frame_rdata_reg[alfe_pkg::BIT_W'(alfe_pkg::BITS_PER_LED - 1)
                                       - bit_cursor_reg];
    assign bit_wrap  = (bit_cursor_reg == alfe_pkg::BIT_W'(alfe_pkg::BITS_PER_LED - 1));
    assign lc_inc    = latch_count_reg + alfe_pkg::SLOTS_W'(1);

    always_comb
    begin
        if (in_bits)
        begin
            tick_duty = frame_bit ? one_duty_reg : zero_duty_reg;
            tick_last = bit_wrap && (led_cursor_reg == LC_W'(LED_COUNT - 1)) &&
                        (latch_slots_reg == '0);
        end
        else
        begin
            tick_duty = latch_duty_reg;
            tick_last = (lc_inc == '0) || (lc_inc >= latch_slots_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg     <= 1'b0;
            led_cursor_reg  <= '0;
            bit_cursor_reg  <= '0;
            latch_count_reg <= '0;
        end
        else if (cmd.frame_start)
        begin
            sending_reg     <= 1'b1;
            led_cursor_reg  <= '0;
            bit_cursor_reg  <= '0;
            latch_count_reg <= '0;
        end
        else if (cmd.tick_step)
        begin
            if (in_bits)
            begin
                if (bit_wrap)
                begin
                    bit_cursor_reg <= '0;
                    led_cursor_reg <= led_cursor_reg + LC_W'(1);
                end
                else
                begin
                    bit_cursor_reg <= bit_cursor_reg + alfe_pkg::BIT_W'(1);
                end
            end
            else
            begin
                latch_count_reg <= lc_inc;
            end
            if (tick_last)
            begin
                sending_reg <= 1'b0;
            end
        end
    end

    // result fields
    always_comb
    begin
        status_calc = alfe_pkg::STATUS_OK;
        if ((item_reg.cmd == alfe_pkg::CMD_WRITE) && !idx_ok)
        begin
            status_calc = alfe_pkg::STATUS_RANGE;
        end
        else if ((item_reg.cmd == alfe_pkg::CMD_START) && sending_reg)
        begin
            status_calc = alfe_pkg::STATUS_BUSY;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            status_reg     <= status_calc;
            duty_reg       <= cmd.tick_step ? tick_duty : '0;
            slot_valid_reg <= cmd.tick_step;
            frame_last_reg <= cmd.tick_step && tick_last;
        end
        if (cmd.res_load)
        begin
            rsp_reg.status     <= status_reg;
            rsp_reg.duty_code  <= duty_reg;
            rsp_reg.slot_valid <= slot_valid_reg;
            rsp_reg.frame_last <= frame_last_reg;
            rsp_reg.busy_out   <= sending_reg;
        end
    end

endmodule

// ----- rtl/addressable_led_frame_encoder_core.sv -----
// Addressable LED frame encoder: pixel store, brightness snapshot, GRB slot codes.
// Steps: a write, tick or unused command is decoded, then its result is registered;
// fill/clear sweep all pixels first; a frame start snapshots all pixels, then drains.
// Throughput: one item at a time; the next item is taken the cycle after the result
// is registered, while that result may still wait on the output.
// Reset: asynchronous, then a clearing pass zeroes the pixel store.
module addressable_led_frame_encoder_core #(
    parameter int LED_COUNT = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    alfe_req_if.sink   req,
    alfe_rsp_if.source rsp,
    alfe_cfg_if.sink   cfg
);

    alfe_pkg::ctrl_cmd_t  ctrl_cmd;
    alfe_pkg::ctrl_stat_t ctrl_stat;

    assign cfg.ready = 1'b1;

    alfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (ctrl_stat),
        .cmd       (ctrl_cmd)
    );

    alfe_datapath #(
        .LED_COUNT (LED_COUNT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req.data),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.data),
        .cmd      (ctrl_cmd),
        .stat     (ctrl_stat),
        .rsp_data (rsp.data)
    );

endmodule
